// ===== hdl/rbe_pkg.sv =====
`default_nettype none

package rbe_pkg;

  // Fixed widths of the coder state and of the transaction fields.
  localparam int STATE_W    = 24;
  localparam int BYTE_W     = 8;
  localparam int KIND_W     = 2;
  localparam int FREQ_W     = 11;
  localparam int RECIP_W    = 32;
  localparam int CUM_W      = 10;
  localparam int WORD_W     = 32;
  localparam int PRODUCT_W  = STATE_W + RECIP_W;

  // Defaults for the top-level parameters.
  localparam int PROB_BITS_DEF      = 10;
  localparam int LOW_BOUND_BITS_DEF = 16;

  // Item kinds; the fourth code is ignored.
  typedef enum logic [KIND_W-1:0] {
    KIND_SYMBOL = 2'd0,
    KIND_BIT    = 2'd1,
    KIND_FLUSH  = 2'd2
  } kind_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RENORM,
    ST_MUL_Q,
    ST_MUL_QF,
    ST_CORR,
    ST_UPDATE,
    ST_FLUSH
  } seq_state_t;

endpackage

`default_nettype wire

// ===== hdl/rbe_mul.sv =====
`default_nettype none

module rbe_mul (
  input  wire logic                          clk,
  input  wire logic [rbe_pkg::STATE_W-1:0]   mul_a,
  input  wire logic [rbe_pkg::RECIP_W-1:0]   mul_b,
  output logic      [rbe_pkg::PRODUCT_W-1:0] product
);

  import rbe_pkg::*;

  // Shared 24 x 32 multiplier with a registered product.
  always_ff @(posedge clk) begin
    product <= PRODUCT_W'(mul_a) * PRODUCT_W'(mul_b);
  end

endmodule

`default_nettype wire

// ===== hdl/rans_byte_encoder_top.sv =====
`default_nettype none

// Channel  Direction  Handshake            Payload
// input    in         in_valid / in_stall  kind, freq, recip, cum_freq, bit_value
// output   out        out_valid / out_stall out_byte, last
//
// One input transaction is taken at a time; in_stall is high from acceptance until
// the coder state has been updated. A symbol is renormalized and then passes through
// the dependent multiply, multiply-subtract and correction that reuse the one
// multiplier in rbe_mul; a bit item is renormalized, and a flush emits 3 bytes.
// Every emitted byte waits for a free output register, so out_stall holds the
// transaction back. Reset is synchronous and loads the coder state with
// 2^LOW_BOUND_BITS.

module rans_byte_encoder_top #(
  parameter int PROB_BITS      = rbe_pkg::PROB_BITS_DEF,
  parameter int LOW_BOUND_BITS = rbe_pkg::LOW_BOUND_BITS_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic [rbe_pkg::KIND_W-1:0]    kind,
  input  wire logic [rbe_pkg::FREQ_W-1:0]    freq,
  input  wire logic [rbe_pkg::RECIP_W-1:0]   recip,
  input  wire logic [rbe_pkg::CUM_W-1:0]     cum_freq,
  input  wire logic                          bit_value,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic      [rbe_pkg::BYTE_W-1:0]    out_byte,
  output logic                               last
);

  import rbe_pkg::*;

  // Renormalization shift: the symbol bound is freq << RENORM_SHIFT.
  localparam int RENORM_SHIFT = LOW_BOUND_BITS + BYTE_W - PROB_BITS;
  // Bound for an equiprobable bit, whose frequency is half the total.
  localparam logic [WORD_W-1:0] BIT_UPPER = WORD_W'(1) << (LOW_BOUND_BITS + BYTE_W - 1);
  localparam logic [STATE_W-1:0] INIT_STATE = STATE_W'(1) << LOW_BOUND_BITS;
  localparam logic [STATE_W-1:0] HALF_FREQ  = STATE_W'(1) << (PROB_BITS - 1);
  localparam logic [STATE_W-1:0] LOW_MASK   = HALF_FREQ - STATE_W'(1);

  seq_state_t state, state_next;

  // The coder state is renormalized in place, so one register serves as the
  // working copy during a transaction.
  logic [STATE_W-1:0] cst, cst_next;
  logic [1:0]         cnt, cnt_next;

  // Captured fields of the transaction in progress.
  logic [KIND_W-1:0]  kind_r;
  logic [FREQ_W-1:0]  freq_r;
  logic [RECIP_W-1:0] recip_r;
  logic [CUM_W-1:0]   cum_r;
  logic               bit_r;
  logic [WORD_W-1:0]  upper_r;

  // Quotient and remainder across the divide steps.
  logic [STATE_W-1:0] q_r, q_next;
  logic [WORD_W-1:0]  r_r, r_next;

  logic [STATE_W-1:0]   mul_a;
  logic [RECIP_W-1:0]   mul_b;
  logic [PRODUCT_W-1:0] product;

  logic               in_acc;
  logic               out_free;
  logic               emit;
  logic [BYTE_W-1:0]  emit_byte;
  logic               emit_last;

  logic [STATE_W-1:0] cst_shift;
  logic [STATE_W-1:0] bit_st;
  logic [STATE_W-1:0] q_shift;
  logic [WORD_W-1:0]  r_raw;
  logic               renorm_go;
  logic               corr;

  assign in_stall = (state != ST_IDLE);
  assign in_acc   = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;

  assign cst_shift = cst >> BYTE_W;
  assign renorm_go = (cnt != 2'd2) && ({8'b0, cst} >= upper_r);

  // Bit coding inserts the bit at position PROB_BITS-1 and moves the upper part up.
  assign bit_st  = ((cst >> (PROB_BITS - 1)) << PROB_BITS) | (cst & LOW_MASK) |
                   (bit_r ? HALF_FREQ : '0);
  assign q_shift = q_r << PROB_BITS;

  rbe_mul u_mul (
    .clk     (clk),
    .mul_a   (mul_a),
    .mul_b   (mul_b),
    .product (product)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      cst   <= INIT_STATE;
      cnt   <= 2'd0;
    end else begin
      state <= state_next;
      cst   <= cst_next;
      cnt   <= cnt_next;
    end
  end

  always_ff @(posedge clk) begin
    q_r <= q_next;
    r_r <= r_next;
    if (in_acc) begin
      kind_r  <= kind;
      freq_r  <= freq;
      recip_r <= recip;
      cum_r   <= cum_freq;
      bit_r   <= bit_value;
      upper_r <= (kind == KIND_SYMBOL) ? (WORD_W'(freq) << RENORM_SHIFT) : BIT_UPPER;
    end
  end

  always_comb begin
    state_next = state;
    cst_next   = cst;
    cnt_next   = cnt;
    q_next     = q_r;
    r_next     = r_r;
    mul_a      = cst;
    mul_b      = recip_r;
    emit       = 1'b0;
    emit_byte  = cst[BYTE_W-1:0];
    emit_last  = 1'b0;
    r_raw      = {8'b0, cst} - product[WORD_W-1:0];
    corr       = 1'b0;
    case (state)
      ST_IDLE: begin
        cnt_next = 2'd0;
        if (in_valid) begin
          case (kind)
            KIND_SYMBOL, KIND_BIT: state_next = ST_RENORM;
            KIND_FLUSH:            state_next = ST_FLUSH;
            default:               state_next = ST_IDLE;
          endcase
        end
      end
      ST_RENORM: begin
        if (renorm_go) begin
          if (out_free) begin
            emit      = 1'b1;
            // Last unless a second byte will follow from the shifted state.
            emit_last = !((cnt == 2'd0) && ({8'b0, cst_shift} >= upper_r));
            cst_next  = cst_shift;
            cnt_next  = cnt + 2'd1;
          end
        end else if (kind_r == KIND_SYMBOL) begin
          state_next = ST_MUL_Q;
        end else begin
          cst_next   = bit_st;
          state_next = ST_IDLE;
        end
      end
      ST_MUL_Q: begin
        mul_a      = cst;
        mul_b      = recip_r;
        state_next = ST_MUL_QF;
      end
      ST_MUL_QF: begin
        q_next     = product[PRODUCT_W-1:RECIP_W];
        mul_a      = product[PRODUCT_W-1:RECIP_W];
        mul_b      = RECIP_W'(freq_r);
        state_next = ST_CORR;
      end
      ST_CORR: begin
        corr       = (r_raw >= WORD_W'(freq_r));
        q_next     = q_r + STATE_W'(corr);
        r_next     = r_raw - (corr ? WORD_W'(freq_r) : '0);
        state_next = ST_UPDATE;
      end
      ST_UPDATE: begin
        cst_next   = q_shift + r_r[STATE_W-1:0] + STATE_W'(cum_r);
        state_next = ST_IDLE;
      end
      ST_FLUSH: begin
        if (out_free) begin
          emit      = 1'b1;
          emit_last = (cnt == 2'd2);
          cnt_next  = cnt + 2'd1;
          if (cnt == 2'd2) begin
            cst_next   = INIT_STATE;
            state_next = ST_IDLE;
          end else begin
            cst_next = cst_shift;
          end
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Output register: holds one byte transaction until the consumer takes it.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_byte <= emit_byte;
      last     <= emit_last;
    end
  end

  a_emit_free: assert property (@(posedge clk) disable iff (rst)
    emit |-> (!out_valid || !out_stall))
    else $error("byte emitted over a pending output transaction");

  a_renorm_count: assert property (@(posedge clk) disable iff (rst)
    (state == ST_RENORM) |-> (cnt != 2'd3))
    else $error("more than two renormalization bytes");

  a_flush_reload: assert property (@(posedge clk) disable iff (rst)
    ($past(state) == ST_FLUSH && state == ST_IDLE) |-> (cst == INIT_STATE))
    else $error("flush did not reload the initial state");

  a_flush_last: assert property (@(posedge clk) disable iff (rst)
    (state == ST_FLUSH && emit && emit_last) |=> (state == ST_IDLE))
    else $error("flush did not end on its last byte");

endmodule

`default_nettype wire

// ===== test/tb_top.sv =====
`default_nettype none

// Testbench for the byte-wise rANS encoder core.
//
// A stimulus queue is filled before reset is released: first a short directed
// table, then a few hundred random transactions. One clocked process drives the
// input channel from that queue. Each accepted input transaction is run through a
// local model of the coder, which updates its own copy of the coder state. The
// model pushes the bytes that the transaction should produce onto a queue. A
// second clocked process drives out_stall and compares every accepted output
// transaction with the oldest byte waiting on that queue.

module tb_top;
  import rbe_pkg::*;

  // The coder geometry follows the defaults of the top level.
  localparam int PROB_BITS      = PROB_BITS_DEF;
  localparam int LOW_BOUND_BITS = LOW_BOUND_BITS_DEF;
  localparam int RENORM_SHIFT   = LOW_BOUND_BITS + BYTE_W - PROB_BITS;
  localparam logic [WORD_W-1:0]  HALF_FREQ  = 32'd1 << (PROB_BITS - 1);
  localparam logic [STATE_W-1:0] INIT_STATE = 24'd1 << LOW_BOUND_BITS;

  // The fourth kind code has no member in the package; the block drops it.
  localparam logic [KIND_W-1:0] KIND_IGNORED = 2'd3;

  // A directed row with this count takes its bytes from the model.
  localparam int FROM_MODEL = -1;

  // Item kinds from 0 to 99 below these marks are picked by the random part.
  localparam int PICK_SYMBOL  = 62;
  localparam int PICK_BIT     = 80;
  localparam int PICK_FLUSH   = 86;
  localparam int PICK_ODD_SYM = 94;
  localparam int IDLE_PCT     = 22;
  localparam int N_RANDOM     = 436;

  // One input transaction. For directed rows, n_typed gives the number of bytes
  // typed into typed_bytes (lowest byte first), or FROM_MODEL.
  typedef struct {
    logic [KIND_W-1:0]  kind;
    logic [FREQ_W-1:0]  freq;
    logic [RECIP_W-1:0] recip;
    logic [CUM_W-1:0]   cum;
    logic               bitv;
    int                 n_typed;
    logic [23:0]        typed_bytes;
  } item_t;

  // One output transaction.
  typedef struct {
    logic [BYTE_W-1:0] b;
    logic              last;
  } coded_byte_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  // Every input of the block starts at a known value.
  logic               in_valid  = 1'b0;
  logic [KIND_W-1:0]  kind      = '0;
  logic [FREQ_W-1:0]  freq      = '0;
  logic [RECIP_W-1:0] recip     = '0;
  logic [CUM_W-1:0]   cum_freq  = '0;
  logic               bit_value = 1'b0;
  logic               out_stall = 1'b0;

  logic               in_stall;
  logic               out_valid;
  logic [BYTE_W-1:0]  out_byte;
  logic               last;

  rans_byte_encoder_top u_top (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .kind      (kind),
    .freq      (freq),
    .recip     (recip),
    .cum_freq  (cum_freq),
    .bit_value (bit_value),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_byte  (out_byte),
    .last      (last)
  );

  item_t       stim_q[$];
  coded_byte_t byte_q[$];
  item_t       cur_item;
  logic [STATE_W-1:0] coder_st = INIT_STATE;
  int n_sent     = 0;
  int n_accepted = 0;
  int n_total    = 0;
  int n_errors   = 0;

  // While this is high neither side idles, so that a long stretch of
  // back-to-back transactions is covered.
  wire steady = (n_sent >= 200) && (n_sent < 300);

  // The directed table. Typed bytes are given only where they are plain: flushes
  // of a known state, ignored items, a bit from the initial state, and zero
  // frequency, which always renormalizes twice.
  item_t dir_tab [0:23] = '{
    // Flush right after reset: the initial state leaves as 00 00 01.
    '{KIND_FLUSH,   11'd0,    32'h0000_0000, 10'd0,    1'b0, 3, 24'h010000},
    // The fourth kind with every field at its top: nothing happens.
    '{KIND_IGNORED, 11'd2047, 32'hFFFF_FFFF, 10'd1023, 1'b1, 0, 24'h000000},
    // A bit from the initial state is far below the renormalization bound.
    '{KIND_BIT,     11'd0,    32'h0000_0000, 10'd0,    1'b0, 0, 24'h000000},
    '{KIND_BIT,     11'd2047, 32'hFFFF_FFFF, 10'd1023, 1'b1, FROM_MODEL, 24'h0},
    '{KIND_FLUSH,   11'd2047, 32'hFFFF_FFFF, 10'd1023, 1'b1, FROM_MODEL, 24'h0},
    // The flush reloaded the initial state.
    '{KIND_FLUSH,   11'd0,    32'h0000_0000, 10'd0,    1'b0, 3, 24'h010000},
    // Zero frequency with zero reciprocal: two low bytes of 0x010000.
    '{KIND_SYMBOL,  11'd0,    32'h0000_0000, 10'd0,    1'b0, 2, 24'h000000},
    '{KIND_FLUSH,   11'd0,    32'h0000_0000, 10'd0,    1'b0, FROM_MODEL, 24'h0},
    '{KIND_SYMBOL,  11'd1024, 32'hFFFF_FFFF, 10'd0,    1'b1, FROM_MODEL, 24'h0},
    '{KIND_SYMBOL,  11'd1,    32'hFFFF_FFFF, 10'd1023, 1'b0, FROM_MODEL, 24'h0},
    '{KIND_SYMBOL,  11'd2047, 32'h8000_0000, 10'd1023, 1'b1, FROM_MODEL, 24'h0},
    '{KIND_SYMBOL,  11'd512,  32'h0080_0000, 10'd512,  1'b0, FROM_MODEL, 24'h0},
    // A run of bits pushes the state up until it renormalizes.
    '{KIND_BIT,     11'd0,    32'h0000_0000, 10'd0,    1'b1, FROM_MODEL, 24'h0},
    '{KIND_BIT,     11'd0,    32'h0000_0000, 10'd0,    1'b1, FROM_MODEL, 24'h0},
    '{KIND_BIT,     11'd0,    32'h0000_0000, 10'd0,    1'b0, FROM_MODEL, 24'h0},
    '{KIND_BIT,     11'd0,    32'h0000_0000, 10'd0,    1'b1, FROM_MODEL, 24'h0},
    '{KIND_BIT,     11'd0,    32'h0000_0000, 10'd0,    1'b1, FROM_MODEL, 24'h0},
    '{KIND_BIT,     11'd0,    32'h0000_0000, 10'd0,    1'b1, FROM_MODEL, 24'h0},
    '{KIND_BIT,     11'd0,    32'h0000_0000, 10'd0,    1'b0, FROM_MODEL, 24'h0},
    '{KIND_BIT,     11'd0,    32'h0000_0000, 10'd0,    1'b1, FROM_MODEL, 24'h0},
    '{KIND_SYMBOL,  11'd3,    32'h5555_5555, 10'd1021, 1'b0, FROM_MODEL, 24'h0},
    // Right frequency, wrong reciprocal: the single correction falls short.
    '{KIND_SYMBOL,  11'd1024, 32'h0000_0000, 10'd0,    1'b0, FROM_MODEL, 24'h0},
    '{KIND_IGNORED, 11'd0,    32'h0000_0000, 10'd0,    1'b0, 0, 24'h000000},
    '{KIND_FLUSH,   11'd0,    32'h0000_0000, 10'd0,    1'b0, FROM_MODEL, 24'h0}
  };

  // Codes one transaction against coder_st. The bytes it causes are returned
  // lowest first in byte_buf, and their number is the return value.
  function automatic int encode_item(input item_t it, output logic [23:0] byte_buf);
    logic [WORD_W-1:0] st;
    logic [WORD_W-1:0] upper;
    logic [WORD_W-1:0] f;
    logic [WORD_W-1:0] q;
    logic [WORD_W-1:0] r;
    logic [WORD_W-1:0] nxt;
    logic [63:0]       prod;
    int                n;
    n        = 0;
    byte_buf = '0;
    st       = {8'h00, coder_st};
    f        = 32'(it.freq);
    // The symbol bound uses freq as given; a bit uses half the total.
    upper    = (it.kind == KIND_SYMBOL) ? (f << RENORM_SHIFT) : (HALF_FREQ << RENORM_SHIFT);
    if (it.kind == KIND_SYMBOL || it.kind == KIND_BIT) begin
      while (n < 2 && st >= upper) begin
        byte_buf[8*n +: 8] = st[7:0];
        st = st >> BYTE_W;
        n++;
      end
    end
    case (it.kind)
      KIND_SYMBOL: begin
        // The quotient comes from the reciprocal; all of it wraps at 32 bits.
        prod = {32'h0, st} * {32'h0, it.recip};
        q    = prod[63:32];
        r    = st - q * f;
        if (r >= f) begin
          q = q + 1;
          r = r - f;
        end
        nxt      = (q << PROB_BITS) + r + 32'(it.cum);
        coder_st = nxt[STATE_W-1:0];
      end
      KIND_BIT: begin
        nxt = ((st >> (PROB_BITS - 1)) << PROB_BITS) + (st & (HALF_FREQ - 1))
              + (it.bitv ? HALF_FREQ : 32'd0);
        coder_st = nxt[STATE_W-1:0];
      end
      KIND_FLUSH: begin
        byte_buf = st[23:0];
        n        = 3;
        coder_st = INIT_STATE;
      end
      default: begin
      end
    endcase
    return n;
  endfunction

  // Random transactions. Most symbols are well formed: a frequency of 1 to 1024,
  // a matching reciprocal and a cumulative frequency that fits. The rest is bits,
  // flushes, symbols with arbitrary fields, and the ignored kind.
  function automatic item_t rand_item();
    item_t       it;
    int          pick;
    logic [63:0] quot;
    it.kind        = KIND_IGNORED;
    it.freq        = 11'($urandom_range(2047, 0));
    it.recip       = $urandom;
    it.cum         = 10'($urandom_range(1023, 0));
    it.bitv        = 1'($urandom_range(1, 0));
    it.n_typed     = FROM_MODEL;
    it.typed_bytes = '0;
    pick = $urandom_range(99, 0);
    if (pick < PICK_SYMBOL) begin
      it.kind = KIND_SYMBOL;
      // Half of the symbols are rare ones, which renormalize more often.
      if ($urandom_range(1, 0) == 0) begin
        it.freq = 11'($urandom_range(16, 1));
      end else begin
        it.freq = 11'($urandom_range(1024, 1));
      end
      quot     = 64'h1_0000_0000 / 64'(it.freq);
      it.recip = (it.freq == 11'd1) ? 32'hFFFF_FFFF : quot[31:0];
      it.cum   = 10'($urandom_range(1024 - int'(it.freq), 0));
    end else if (pick < PICK_BIT) begin
      it.kind = KIND_BIT;
    end else if (pick < PICK_FLUSH) begin
      it.kind = KIND_FLUSH;
    end else if (pick < PICK_ODD_SYM) begin
      it.kind = KIND_SYMBOL;
    end
    return it;
  endfunction

  initial begin
    forever #4 clk = ~clk;
  end

  // Input side. On acceptance the model runs and the expected bytes are queued;
  // then the next transaction goes out unless this cycle is an idle one. The
  // payload only changes when no transaction is pending or one was just taken.
  always @(posedge clk) begin : drive_in
    logic [23:0] byte_buf;
    int          n;
    int          k;
    logic        took;
    took = 1'b0;
    if (!rst) begin
      if (in_valid && !in_stall) begin
        took = 1'b1;
        n    = encode_item(cur_item, byte_buf);
        // Typed rows replace the model's bytes; the model state still advances.
        if (cur_item.n_typed != FROM_MODEL) begin
          n        = cur_item.n_typed;
          byte_buf = cur_item.typed_bytes;
        end
        for (k = 0; k < n; k++) begin
          byte_q.push_back('{byte_buf[8*k +: 8], (k == n - 1)});
        end
        n_accepted++;
      end
      if (!in_valid || took) begin
        if (stim_q.size() > 0 && (steady || $urandom_range(99, 0) >= IDLE_PCT)) begin
          cur_item  = stim_q.pop_front();
          kind      <= cur_item.kind;
          freq      <= cur_item.freq;
          recip     <= cur_item.recip;
          cum_freq  <= cur_item.cum;
          bit_value <= cur_item.bitv;
          in_valid  <= 1'b1;
          n_sent++;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Output side. Each accepted byte is compared with the oldest one expected;
  // a byte that arrives while nothing is expected is an error of its own.
  always @(posedge clk) begin : check_out
    coded_byte_t want;
    if (!rst) begin
      if (out_valid && !out_stall) begin
        if (byte_q.size() == 0) begin
          $display("%0t: unexpected byte %02h last %0b", $time, out_byte, last);
          n_errors++;
        end else begin
          want = byte_q.pop_front();
          if (out_byte !== want.b) begin
            $display("%0t: out_byte expected %02h, actual %02h", $time, want.b, out_byte);
            n_errors++;
          end
          if (last !== want.last) begin
            $display("%0t: last expected %0b, actual %0b", $time, want.last, last);
            n_errors++;
          end
        end
      end
      out_stall <= !steady && ($urandom_range(99, 0) < IDLE_PCT);
    end
  end

  // Main sequence: build the stimulus, release reset, wait for every input
  // transaction to be taken and every expected byte to arrive, then keep the clock
  // running so that a stray byte would still be caught.
  initial begin : main
    int i;
    for (i = 0; i < $size(dir_tab); i++) begin
      stim_q.push_back(dir_tab[i]);
    end
    for (i = 0; i < N_RANDOM; i++) begin
      stim_q.push_back(rand_item());
    end
    n_total = stim_q.size();
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    while (n_accepted < n_total) @(posedge clk);
    while (byte_q.size() != 0) @(posedge clk);
    repeat (24) @(posedge clk);
    if (n_errors == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end

  // Watchdog. The slowest correct run is far below this: a few hundred
  // transactions, plus output stalls.
  initial begin : watchdog
    #2_000_000;
    $display("tb_top: done, errors");
    $finish;
  end

endmodule

`default_nettype wire
